/* src/tdm_pkg.sv */
// Package: shared constants, types and helper functions of the tile deduplicator.
`default_nettype none
package tdm_pkg;
  localparam int unsigned MaxTiles   = 512;
  localparam int unsigned TileRows   = 8;
  localparam int unsigned TileCols   = 8;
  localparam int unsigned MaxColours = 16;
  localparam int unsigned IdxW       = $clog2(MaxTiles);
  localparam int unsigned CntW       = $clog2(MaxTiles + 1);
  localparam int unsigned RowW       = (TileRows > 1) ? $clog2(TileRows) : 1;
  localparam int unsigned AddrW      = $clog2(MaxTiles * TileRows);
  localparam int unsigned NumCells   = 4;

  localparam logic [15:0] FlagHflip   = 16'h0200;
  localparam logic [15:0] FlagVflip   = 16'h0400;
  localparam logic [15:0] FlagSprite  = 16'h0800;
  localparam logic [15:0] FlagInFront = 16'h1000;

  localparam logic [2:0] RegRemoveDup = 3'd0;
  localparam logic [2:0] RegMirror    = 3'd1;
  localparam logic [2:0] RegOffset    = 3'd2;
  localparam logic [2:0] RegSprite    = 3'd3;
  localparam logic [2:0] RegInFront   = 3'd4;

  typedef logic [TileCols*8-1:0] row_t;

  // row travelling down the cell chain
  typedef struct packed {
    logic            vld;
    logic [RowW-1:0] row;
    row_t            data;
  } beat_t;

  function automatic row_t clamp_row(row_t r);
    row_t res;
    res = '0;
    for (int x = 0; x < TileCols; x++) begin
      if (r[8*x +: 8] < 8'(MaxColours)) res[8*x +: 8] = r[8*x +: 8];
    end
    return res;
  endfunction

  function automatic row_t mirror_row(row_t r);
    row_t res;
    res = '0;
    for (int x = 0; x < TileCols; x++) begin
      res[8*(TileCols-1-x) +: 8] = r[8*x +: 8];
    end
    return res;
  endfunction
endpackage
`default_nettype wire

/* src/tile_dedup_with_mirror_match_unit.sv */
// Top level: row collection, tile store, chain of compare cells and result register.
//
//  channel | direction | handshake          | payload
//  in      | sink      | in_valid/in_ready  | pixel_row, new_image
//  out     | source    | out_valid/out_ready| map_word .. store_full
//  cfg     | sink      | APB psel/penable   | five registers at 4*i
//
// A row that does not finish a tile is only buffered; the unit stays idle. A finishing row streams
// tile_count*TileRows stored rows from the single-port store past four cells
// (one per orientation), then writes TileRows rows and registers the result.
// After reset the store is empty; no clearing pass is needed.
// The output register holds a result until taken; the next item waits for it.
`default_nettype none
module tile_dedup_with_mirror_match_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] pixel_row_i,
  input  wire logic        new_image_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      map_word_o,
  output logic [8:0]       tile_index_o,
  output logic             dup_found_o,
  output logic             flip_x_o,
  output logic             flip_y_o,
  output logic             stored_o,
  output logic             store_full_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import tdm_pkg::*;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StScan  = 4'b0010,
    StDrain = 4'b0100,
    StWrite = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic rmdup_q, mirror_q, spr_q, front_q;
  logic [15:0] offs_q;
  row_t rowbuf_q [TileRows];
  logic [RowW-1:0] rcnt_q;
  logic [CntW-1:0] tcnt_q;
  logic [AddrW-1:0] addr_q;
  logic [CntW-1:0] tile_q;
  logic [RowW-1:0] row_q;
  logic rd_vld_q;
  logic [RowW-1:0] rd_row_q;
  row_t rd_data_q;
  row_t mem [MaxTiles*TileRows];
  logic [CntW-1:0] drain_q;
  logic [RowW-1:0] wrow_q;
  logic [CntW-1:0] pend_q;
  row_t cand [NumCells][TileRows];
  beat_t chain [NumCells+1];
  logic [NumCells-1:0] eq;
  logic [CntW-1:0] res_tile_q [NumCells+1];
  logic clr;

  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    case (paddr[4:2])
      RegRemoveDup: prdata[0] = rmdup_q;
      RegMirror:    prdata[0] = mirror_q;
      RegOffset:    prdata[15:0] = offs_q;
      RegSprite:    prdata[0] = spr_q;
      RegInFront:   prdata[0] = front_q;
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rmdup_q <= 1'b1; mirror_q <= 1'b1; offs_q <= '0; spr_q <= 1'b0; front_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        RegRemoveDup: rmdup_q  <= pwdata[0];
        RegMirror:    mirror_q <= pwdata[0];
        RegOffset:    offs_q   <= pwdata[15:0];
        RegSprite:    spr_q    <= pwdata[0];
        RegInFront:   front_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == StIdle) && !out_valid_o;
  wire in_fire = in_valid_i && in_ready_o;
  wire [RowW-1:0] wr_row = (new_image_i || rcnt_q == RowW'(TileRows - 1)) && new_image_i ?
                           '0 : rcnt_q;
  wire last_row = (wr_row == RowW'(TileRows - 1));
  wire [CntW-1:0] cnt_now = new_image_i ? '0 : tcnt_q;

  for (genvar r = 0; r < TileRows; r++) begin : g_cand
    assign cand[0][r] = rowbuf_q[r];
    assign cand[1][r] = mirror_row(rowbuf_q[r]);
    assign cand[2][r] = rowbuf_q[TileRows-1-r];
    assign cand[3][r] = mirror_row(rowbuf_q[TileRows-1-r]);
  end

  assign clr = (state_q == StIdle);
  assign chain[0].vld  = rd_vld_q;
  assign chain[0].row  = rd_row_q;
  assign chain[0].data = rd_data_q;
  for (genvar c = 0; c < NumCells; c++) begin : g_cell
    tdm_cell u_cell (
      .clk_i, .rst_ni, .clear_i(clr),
      .cand_i(cand[c][chain[c].row]), .beat_i(chain[c]),
      .beat_o(chain[c+1]), .tile_eq_o(eq[c])
    );
  end

  always_ff @(posedge clk_i) begin
    res_tile_q[0] <= tile_q;
    for (int c = 0; c < NumCells; c++) res_tile_q[c+1] <= res_tile_q[c];
  end

  // best hit: lowest orientation, then lowest tile; tile seen in cell c at different times
  logic [NumCells-1:0] use_c;
  logic [CntW-1:0] ctile [NumCells];
  always_comb begin
    for (int c = 0; c < NumCells; c++) begin
      ctile[c] = res_tile_q[c+1];
      use_c[c] = eq[c] && (c == 0 || mirror_q);
    end
  end
  logic found [NumCells];
  logic [IdxW-1:0] fidx [NumCells];

  wire any_dup = found[0] || found[1] || found[2] || found[3];
  logic [1:0] bo;
  always_comb begin
    bo = 2'd3;
    if (found[2]) bo = 2'd2;
    if (found[1]) bo = 2'd1;
    if (found[0]) bo = 2'd0;
  end
  wire need_store = !any_dup || !rmdup_q;
  wire store_ok   = need_store && (pend_q < CntW'(MaxTiles));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; rcnt_q <= '0; tcnt_q <= '0; out_valid_o <= 1'b0;
      rd_vld_q <= 1'b0;
      for (int c = 0; c < NumCells; c++) found[c] <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      rd_vld_q <= 1'b0;
      if (in_fire) begin
        if (new_image_i) tcnt_q <= '0;
        rcnt_q <= last_row ? '0 : wr_row + 1'b1;
        for (int c = 0; c < NumCells; c++) found[c] <= 1'b0;
      end
      if (state_q == StScan) rd_vld_q <= (tile_q < pend_q);
      for (int c = 0; c < NumCells; c++)
        if (use_c[c] && !found[c]) found[c] <= 1'b1;
      if (state_q == StWrite && wrow_q == RowW'(TileRows - 1)) begin
        out_valid_o <= 1'b1;
        if (store_ok) tcnt_q <= pend_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NumCells; c++)
      if (use_c[c] && !found[c]) fidx[c] <= ctile[c][IdxW-1:0];
    if (in_fire) begin
      rowbuf_q[wr_row] <= clamp_row(pixel_row_i);
      pend_q <= cnt_now;
      tile_q <= '0; row_q <= '0; addr_q <= '0; drain_q <= '0; wrow_q <= '0;
    end
    if (state_q == StScan) begin
      rd_data_q <= mem[addr_q];
      rd_row_q  <= row_q;
      addr_q    <= addr_q + 1'b1;
      row_q     <= (row_q == RowW'(TileRows - 1)) ? '0 : row_q + 1'b1;
      if (row_q == RowW'(TileRows - 1)) tile_q <= tile_q + 1'b1;
      if (tile_q >= pend_q) begin
        tile_q <= tile_q;
      end
    end
    if (state_q == StDrain) drain_q <= drain_q + 1'b1;
    if (state_q == StWrite) begin
      if (store_ok)
        mem[AddrW'(pend_q) * AddrW'(TileRows) + AddrW'(wrow_q)] <= rowbuf_q[wrow_q];
      wrow_q <= wrow_q + 1'b1;
      if (wrow_q == RowW'(TileRows - 1)) begin
        logic [CntW-1:0] idx;
        idx = any_dup ? CntW'(fidx[bo]) : (store_ok ? pend_q : '0);
        tile_index_o   <= idx[IdxW-1:0];
        dup_found_o    <= any_dup;
        flip_x_o       <= any_dup && bo[0];
        flip_y_o       <= any_dup && bo[1];
        stored_o       <= store_ok;
        store_full_o   <= need_store && !store_ok;
        map_word_o     <= (16'(idx) + offs_q) | ((any_dup && bo[0]) ? FlagHflip : '0) |
                          ((any_dup && bo[1]) ? FlagVflip : '0) |
                          (spr_q ? FlagSprite : '0) | (front_q ? FlagInFront : '0);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_fire && last_row) state_d = StScan;
      StScan:  if (tile_q >= pend_q) state_d = StDrain;
      StDrain: if (drain_q == CntW'(NumCells + 2)) state_d = StWrite;
      StWrite: if (wrow_q == RowW'(TileRows - 1)) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end
endmodule
`default_nettype wire

/* src/tdm_cell.sv */
// Compare cell: checks one orientation of the candidate against streamed stored rows.
`default_nettype none
module tdm_cell (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 clear_i,
  input  wire tdm_pkg::row_t        cand_i,
  input  wire tdm_pkg::beat_t       beat_i,
  output tdm_pkg::beat_t            beat_o,
  output logic                      tile_eq_o
);
  import tdm_pkg::*;
  logic ok_q, ok_d;
  logic vld_q;
  logic [RowW-1:0] row_q;
  row_t data_q;

  always_comb begin
    ok_d = ok_q;
    if (beat_i.vld) begin
      if (beat_i.row == '0) ok_d = (beat_i.data == cand_i);
      else ok_d = ok_q && (beat_i.data == cand_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q  <= 1'b0;
      vld_q <= 1'b0;
    end else begin
      ok_q  <= clear_i ? 1'b0 : ok_d;
      vld_q <= clear_i ? 1'b0 : beat_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q  <= beat_i.row;
    data_q <= beat_i.data;
  end

  assign beat_o    = {vld_q, row_q, data_q};
  assign tile_eq_o = ok_q && vld_q && (row_q == RowW'(TileRows - 1));
endmodule
`default_nettype wire

/* src/tdm_checker.sv */
// Checker: port-level properties of the tile deduplicator, bound to the top level.
`default_nettype none
module tdm_checker (
  input wire logic clk_i, rst_ni, in_ready_o, out_valid_o, out_ready_i,
  input wire logic dup_found_o, flip_x_o, flip_y_o, stored_o, store_full_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (flip_x_o || flip_y_o) |-> dup_found_o) else $error("flip without match");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(stored_o && store_full_o)) else $error("stored and full");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("accepting while result waits");
endmodule
bind tile_dedup_with_mirror_match_unit tdm_checker u_chk (.*);
`default_nettype wire

/* bench/tb.sv */
// Testbench for the tile deduplicator: random tiles, config phases, scoreboard check.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tdm_pkg::*;

  typedef struct packed {
    logic [15:0] map_word;
    logic [8:0]  tile_index;
    logic        dup_found;
    logic        flip_x;
    logic        flip_y;
    logic        stored;
    logic        store_full;
  } tile_res_t;

  class dedup_scoreboard;
    logic [63:0] tiles[MaxTiles][TileRows];
    logic [63:0] rows[TileRows];
    int unsigned n_tiles;
    int unsigned n_rows;
    logic rm_dup, mirror, pal, front;
    logic [15:0] offset;
    tile_res_t pending[$];
    int errors;

    function void clear_all();
      n_tiles = 0; n_rows = 0; rm_dup = 1; mirror = 1; offset = 0; pal = 0; front = 0;
      errors = 0;
    endfunction

    function logic [63:0] sanitize(logic [63:0] r);
      logic [63:0] res;
      res = '0;
      for (int x = 0; x < 8; x++) if (r[8*x +: 8] < 16) res[8*x +: 8] = r[8*x +: 8];
      return res;
    endfunction

    function logic [63:0] flip_h(logic [63:0] r);
      logic [63:0] res;
      for (int x = 0; x < 8; x++) res[8*(7-x) +: 8] = r[8*x +: 8];
      return res;
    endfunction

    function void note_row(logic [63:0] px, logic newimg);
      logic [63:0] cand[4][TileRows];
      tile_res_t r;
      int unsigned idx;
      bit hit, same;
      int unsigned n_orient;
      if (newimg) begin n_tiles = 0; n_rows = 0; end
      rows[n_rows] = sanitize(px);
      n_rows++;
      if (n_rows < TileRows) return;
      n_rows = 0;
      for (int i = 0; i < TileRows; i++) begin
        cand[0][i] = rows[i];
        cand[1][i] = flip_h(rows[i]);
        cand[2][i] = rows[TileRows-1-i];
        cand[3][i] = flip_h(rows[TileRows-1-i]);
      end
      r = '0; idx = 0; hit = 0;
      n_orient = mirror ? 4 : 1;
      for (int o = 0; o < n_orient && !hit; o++)
        for (int t = 0; t < n_tiles && !hit; t++) begin
          same = 1;
          for (int i = 0; i < TileRows; i++) if (cand[o][i] != tiles[t][i]) same = 0;
          if (same) begin
            hit = 1; idx = t; r.flip_x = o[0]; r.flip_y = o[1];
          end
        end
      r.dup_found = hit;
      if (!hit || !rm_dup) begin
        if (n_tiles < MaxTiles) begin
          for (int i = 0; i < TileRows; i++) tiles[n_tiles][i] = rows[i];
          if (!hit) idx = n_tiles;
          n_tiles++;
          r.stored = 1;
        end else r.store_full = 1;
      end
      r.tile_index = idx[8:0];
      r.map_word = 16'(idx + offset);
      if (r.flip_x) r.map_word |= FlagHflip;
      if (r.flip_y) r.map_word |= FlagVflip;
      if (pal) r.map_word |= FlagSprite;
      if (front) r.map_word |= FlagInFront;
      pending = {pending, r};
    endfunction

    function void check_result(tile_res_t a);
      tile_res_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %p", a); errors++; return;
      end
      e = pending.pop_front();
      if (a.map_word !== e.map_word) begin
        $error("map_word exp %h got %h", e.map_word, a.map_word); errors++; end
      if (a.tile_index !== e.tile_index) begin
        $error("tile_index exp %0d got %0d", e.tile_index, a.tile_index); errors++; end
      if (a.dup_found !== e.dup_found) begin
        $error("dup_found exp %b got %b", e.dup_found, a.dup_found); errors++; end
      if (a.flip_x !== e.flip_x) begin
        $error("flip_x exp %b got %b", e.flip_x, a.flip_x); errors++; end
      if (a.flip_y !== e.flip_y) begin
        $error("flip_y exp %b got %b", e.flip_y, a.flip_y); errors++; end
      if (a.stored !== e.stored) begin
        $error("stored exp %b got %b", e.stored, a.stored); errors++; end
      if (a.store_full !== e.store_full) begin
        $error("store_full exp %b got %b", e.store_full, a.store_full); errors++; end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, new_image_i;
  logic [63:0] pixel_row_i;
  logic out_valid_o, out_ready_i;
  logic [15:0] map_word_o;
  logic [8:0] tile_index_o;
  logic dup_found_o, flip_x_o, flip_y_o, stored_o, store_full_o;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;

  dedup_scoreboard sb;
  int idle_pct;
  bit hold_off;
  logic [63:0] lib[16][TileRows];

  tile_dedup_with_mirror_match_unit dut (.*);

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("tb NOT OK");
    $finish;
  end

  task automatic apb_write(logic [2:0] reg_id, logic [31:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {reg_id, 2'b00}; pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (reg_id)
      RegRemoveDup: sb.rm_dup = v[0];
      RegMirror:    sb.mirror = v[0];
      RegOffset:    sb.offset = v[15:0];
      RegSprite:    sb.pal = v[0];
      default:      sb.front = v[0];
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_row(logic [63:0] px, logic ni);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1; pixel_row_i <= px; new_image_i <= ni;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_row(px, ni);
  endtask

  task automatic send_tile(ref logic [63:0] t[TileRows], input logic ni);
    for (int i = 0; i < TileRows; i++) send_row(t[i], ni && i == 0);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rnd_row(bit raw);
    logic [63:0] r;
    r = {$urandom, $urandom};
    if (!raw) for (int x = 0; x < 8; x++) r[8*x +: 8] = 8'($urandom_range(15));
    return r;
  endfunction

  task automatic random_phase(int n_tiles, int rowsx);
    logic [63:0] t[TileRows];
    int k;
    for (int n = 0; n < n_tiles; n++) begin
      k = $urandom_range(15);
      for (int i = 0; i < TileRows; i++) t[i] = lib[k][i];
      case ($urandom_range(5))
        0: for (int i = 0; i < TileRows; i++) t[i] = sb.flip_h(lib[k][i]);
        1: for (int i = 0; i < TileRows; i++) t[i] = lib[k][TileRows-1-i];
        2: for (int i = 0; i < TileRows; i++) t[i] = sb.flip_h(lib[k][TileRows-1-i]);
        3: for (int i = 0; i < TileRows; i++) t[i] = rnd_row($urandom_range(1) == 1);
        default: ;
      endcase
      if ($urandom_range(9) == 0) t[$urandom_range(7)][8*$urandom_range(7) +: 8] |= 8'h80;
      send_tile(t, $urandom_range(60) == 0);
    end
    for (int i = 0; i < rowsx; i++) send_row(rnd_row(1), 0);
  endtask

  initial begin
    logic [63:0] t[TileRows];
    sb = new();
    sb.clear_all();
    rst_ni = 0; in_valid_i = 0; pixel_row_i = '0; new_image_i = 0; out_ready_i = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    idle_pct = 0; hold_off = 0;
    for (int k = 0; k < 16; k++)
      for (int i = 0; i < TileRows; i++) lib[k][i] = rnd_row(0);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed
    for (int i = 0; i < TileRows; i++) t[i] = '1;
    send_tile(t, 1);
    for (int i = 0; i < TileRows; i++) t[i] = 64'h0f0e0d0c0b0a0908 + i;
    send_tile(t, 0);
    for (int i = 0; i < TileRows; i++) t[i] = sb.flip_h(64'h0f0e0d0c0b0a0908 + i);
    send_tile(t, 0);
    drain();
    apb_write(RegRemoveDup, 0);
    apb_write(RegMirror, 0);
    apb_write(RegOffset, 32'hffff);
    apb_write(RegSprite, 1);
    apb_write(RegInFront, 1);
    send_tile(t, 0);
    for (int i = 0; i < TileRows; i++) t[i] = 64'h0f0e0d0c0b0a0908 + (TileRows-1-i);
    send_tile(t, 0);
    drain();
    // random phases
    idle_pct = 36;
    random_phase(30, 3);
    drain();
    apb_write(RegRemoveDup, 1);
    apb_write(RegMirror, 1);
    apb_write(RegOffset, $urandom);
    apb_write(RegSprite, 0);
    apb_write(RegInFront, 0);
    idle_pct = 0;
    hold_off = 1;
    random_phase(20, 0);
    hold_off = 0;
    idle_pct = 36;
    random_phase(30, 5);
    drain();
    // distinct tiles after clearing the store, without mirror search
    apb_write(RegMirror, 0);
    apb_write(RegRemoveDup, 0);
    apb_write(RegOffset, 32'hfe00);
    idle_pct = 5;
    for (int n = 0; n < 5; n++) begin
      for (int i = 0; i < TileRows; i++) t[i] = '0;
      t[0][15:0] = {4'h0, n[11:8], 4'h0, n[7:4]};
      t[1][7:0] = {4'h0, n[3:0]};
      send_tile(t, n == 0);
    end
    drain();
    apb_write(RegMirror, 1);
    apb_write(RegRemoveDup, $urandom_range(1));
    apb_write(RegSprite, $urandom_range(1));
    apb_write(RegInFront, $urandom_range(1));
    apb_write(RegOffset, 0);
    idle_pct = 36;
    random_phase(15, 0);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        sb.check_result({map_word_o, tile_index_o, dup_found_o, flip_x_o, flip_y_o,
                         stored_o, store_full_o});
      if (hold_off && hold == 0) begin
        out_ready_i <= 0;
        repeat (2000) @(posedge clk_i);
        hold = 1;
      end else out_ready_i <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
    end
  end
endmodule
